FILE: hw/rtl/neighbor_list_pair_filter_defines.svh
// ----------------------------------------------------------------------------
// neighbor list pair filter assertion macros
// shared property forms for the port checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_LIST_PAIR_FILTER_DEFINES_SVH
`define NEIGHBOR_LIST_PAIR_FILTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define NLPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define NLPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/nlpf_pkg.sv
// ----------------------------------------------------------------------------
// nlpf_pkg
// sizes, codes and controller/datapath interface types of the pair filter
// ----------------------------------------------------------------------------
package nlpf_pkg;

    // sizing
    localparam int MAX_ATOMS     = 4096;
    localparam int MAX_NEIGHBORS = 64;
    localparam int COORD_BITS    = 24;

    // port field widths
    localparam int OP_W       = 2;
    localparam int ATOM_W     = 12;
    localparam int POS_W      = 24;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int D2_W       = 48;
    localparam int TOT_W      = 19;
    localparam int BOX_W      = 25;
    localparam int ACNT_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // derived storage widths
    localparam int ATOM_AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int SLOT_AW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int LEN_W     = $clog2(MAX_NEIGHBORS + 1);
    localparam int CLR_W     = ATOM_AW + 1;
    localparam int ENT_AW    = ATOM_AW + SLOT_AW;
    localparam int ENT_DEPTH = 1 << ENT_AW;

    // arithmetic widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int WRAP_W = ((DIFF_W > BOX_W + 1) ? DIFF_W : BOX_W + 1) + 2;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > D2_W) ? SUM_W : D2_W;

    localparam logic [D2_W-1:0] D2_MAX = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_PAIR  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHELL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 3'd4;

    // register reset values
    localparam logic [BOX_W-1:0]  BOX_RESET   = 25'd16777216;
    localparam logic [D2_W-1:0]   SHELL_RESET = 48'd0;
    localparam logic [ACNT_W-1:0] ACNT_RESET  = 13'd4096;

    // axis select
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic       latch;      // capture request fields
        logic       clr_start;  // arm count sweep for a clear request
        logic       clr_step;   // zero one list count
        logic [1:0] axis;       // axis for diff/wrap
        logic       diff;       // coordinate difference
        logic       wrap;       // minimum image and magnitude
        logic       mult;       // square
        logic       acc;        // accumulate square
        logic       len_rd;     // read home list count
        logic       commit;     // shell test and list append
        logic       ent_rd;     // read list entry
        logic       load_out;   // fill result register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_busy;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/nlpf_ctrl.sv
// ----------------------------------------------------------------------------
// nlpf_ctrl
// sequencer of the pair filter: one request at a time, issues datapath steps
// ----------------------------------------------------------------------------
module nlpf_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [nlpf_pkg::OP_W-1:0]   i_operation,
    output logic                        o_in_ready,
    input  nlpf_pkg::t_sts              i_sts,
    output nlpf_pkg::t_cmd              o_cmd
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_WRAP   = 4'd4;
    localparam logic [3:0] S_MULT   = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_LEN_RD = 4'd7;
    localparam logic [3:0] S_UPDATE = 4'd8;
    localparam logic [3:0] S_ENT_RD = 4'd9;
    localparam logic [3:0] S_FINISH = 4'd10;

    logic [3:0]                  r_state, n_state;
    logic [1:0]                  r_axis, n_axis;
    logic [nlpf_pkg::OP_W-1:0]   r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_axis  <= nlpf_pkg::AXIS_X;
            r_op    <= nlpf_pkg::OP_NOP;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_op       = r_op;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_INIT: begin
                // power-up sweep of all list counts
                o_cmd.clr_step = 1'b1;
                if (!i_sts.clr_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_op        = i_operation;
                    unique case (i_operation)
                        nlpf_pkg::OP_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state         = S_CLEAR;
                        end
                        nlpf_pkg::OP_PAIR: begin
                            n_axis  = nlpf_pkg::AXIS_X;
                            n_state = S_DIFF;
                        end
                        nlpf_pkg::OP_READ, nlpf_pkg::OP_NOP: begin
                            n_state = S_LEN_RD;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (!i_sts.clr_busy) n_state = S_LEN_RD;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_axis == nlpf_pkg::AXIS_Z) begin
                    n_state = S_LEN_RD;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DIFF;
                end
            end
            S_LEN_RD: begin
                o_cmd.len_rd = 1'b1;
                unique case (r_op)
                    nlpf_pkg::OP_PAIR:                   n_state = S_UPDATE;
                    nlpf_pkg::OP_READ:                   n_state = S_ENT_RD;
                    nlpf_pkg::OP_CLEAR, nlpf_pkg::OP_NOP: n_state = S_FINISH;
                endcase
            end
            S_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_ENT_RD: begin
                o_cmd.ent_rd = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

FILE: hw/rtl/nlpf_dp.sv
// ----------------------------------------------------------------------------
// nlpf_dp
// pair filter datapath: registers, minimum image, square, list memories
// ----------------------------------------------------------------------------
module nlpf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nlpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nlpf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [nlpf_pkg::OP_W-1:0]         i_operation,
    input  logic [nlpf_pkg::ATOM_W-1:0]       i_home_atom,
    input  logic [nlpf_pkg::ATOM_W-1:0]       i_other_atom,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_x,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_y,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_z,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_x,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_y,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_z,
    input  logic [nlpf_pkg::SLOT_W-1:0]       i_slot,
    input  nlpf_pkg::t_cmd                    i_cmd,
    output nlpf_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_added,
    output logic                              o_overflow,
    output logic [nlpf_pkg::CNT_W-1:0]        o_neighbor_count,
    output logic [nlpf_pkg::ATOM_W-1:0]       o_entry_value,
    output logic [nlpf_pkg::D2_W-1:0]         o_distance_squared,
    output logic [nlpf_pkg::TOT_W-1:0]        o_total_neighbors
);

    // configuration
    logic [nlpf_pkg::BOX_W-1:0]  r_box_x, r_box_y, r_box_z;
    logic [nlpf_pkg::D2_W-1:0]   r_shell;
    logic [nlpf_pkg::ACNT_W-1:0] r_atom_count;

    // captured request
    logic [nlpf_pkg::OP_W-1:0]   r_op;
    logic [nlpf_pkg::ATOM_W-1:0] r_home, r_other;
    logic [nlpf_pkg::POS_W-1:0]  r_hx, r_hy, r_hz, r_ox, r_oy, r_oz;
    logic [nlpf_pkg::SLOT_W-1:0] r_slot;

    // distance pipeline registers
    logic signed [nlpf_pkg::DIFF_W-1:0] r_diff;
    logic [nlpf_pkg::COORD_BITS-1:0]    r_mag;
    logic [nlpf_pkg::SQ_W-1:0]          r_sq;
    logic [nlpf_pkg::SUM_W-1:0]         r_acc;

    // list state
    logic [nlpf_pkg::LEN_W-1:0]  len_mem [0:nlpf_pkg::MAX_ATOMS-1];
    logic [nlpf_pkg::ATOM_W-1:0] ent_mem [0:nlpf_pkg::ENT_DEPTH-1];
    logic [nlpf_pkg::LEN_W-1:0]  r_len_rd;
    logic [nlpf_pkg::ATOM_W-1:0] r_ent_rd;
    logic [nlpf_pkg::CLR_W-1:0]  r_clr_idx, r_clr_lim;
    logic [nlpf_pkg::TOT_W-1:0]  r_total;
    logic                        r_added, r_ovf;

    // result register
    logic                        r_out_valid;
    logic                        r_o_added, r_o_ovf;
    logic [nlpf_pkg::CNT_W-1:0]  r_o_cnt;
    logic [nlpf_pkg::ATOM_W-1:0] r_o_ent;
    logic [nlpf_pkg::D2_W-1:0]   r_o_d2;
    logic [nlpf_pkg::TOT_W-1:0]  r_o_tot;

    // combinational
    logic [nlpf_pkg::POS_W-1:0]         a_sel, b_sel;
    logic [nlpf_pkg::BOX_W-1:0]         box_sel;
    logic [nlpf_pkg::COORD_BITS-1:0]    a_c, b_c;
    logic signed [nlpf_pkg::DIFF_W-1:0] diff_val;
    logic signed [nlpf_pkg::WRAP_W-1:0] d_w, box_w, d2x, up, dn, nd, nup, ndn, mag_w;
    logic                               wrap_lo, wrap_hi;
    logic                               home_ok, keep, room, store, clr_write, entry_ok;
    logic [nlpf_pkg::ATOM_AW-1:0]       home_addr;
    logic [nlpf_pkg::CLR_W-1:0]         clear_n;
    logic                               len_we;
    logic [nlpf_pkg::ATOM_AW-1:0]       len_waddr;
    logic [nlpf_pkg::LEN_W-1:0]         len_wdata;
    logic [nlpf_pkg::D2_W-1:0]          d2_sat;

    // axis select
    always_comb begin
        unique case (i_cmd.axis)
            nlpf_pkg::AXIS_Y: begin
                a_sel = r_hy; b_sel = r_oy; box_sel = r_box_y;
            end
            nlpf_pkg::AXIS_Z: begin
                a_sel = r_hz; b_sel = r_oz; box_sel = r_box_z;
            end
            default: begin
                a_sel = r_hx; b_sel = r_ox; box_sel = r_box_x;
            end
        endcase
    end

    assign a_c      = nlpf_pkg::COORD_BITS'(a_sel);
    assign b_c      = nlpf_pkg::COORD_BITS'(b_sel);
    assign diff_val = $signed({1'b0, a_c}) - $signed({1'b0, b_c});

    // minimum image: one wrap, then magnitude, all candidates side by side
    assign d_w   = {{(nlpf_pkg::WRAP_W - nlpf_pkg::DIFF_W){r_diff[nlpf_pkg::DIFF_W-1]}}, r_diff};
    assign box_w = {{(nlpf_pkg::WRAP_W - nlpf_pkg::BOX_W){1'b0}}, box_sel};
    assign d2x   = d_w <<< 1;
    assign up    = d_w + box_w;
    assign dn    = d_w - box_w;
    assign nd    = -d_w;
    assign nup   = nd - box_w;
    assign ndn   = box_w - d_w;
    assign wrap_lo = (d2x < -box_w);
    assign wrap_hi = (d2x > box_w);

    always_comb begin
        priority if (wrap_lo) begin
            mag_w = up[nlpf_pkg::WRAP_W-1] ? nup : up;
        end else if (wrap_hi) begin
            mag_w = dn[nlpf_pkg::WRAP_W-1] ? ndn : dn;
        end else begin
            mag_w = d_w[nlpf_pkg::WRAP_W-1] ? nd : d_w;
        end
    end

    // list control
    assign home_ok   = (32'(r_home) < 32'(nlpf_pkg::MAX_ATOMS));
    assign home_addr = nlpf_pkg::ATOM_AW'(r_home);
    assign keep      = home_ok &&
                       (nlpf_pkg::CMP_W'(r_acc) <= nlpf_pkg::CMP_W'(r_shell));
    assign room      = (32'(r_len_rd) < 32'(nlpf_pkg::MAX_NEIGHBORS));
    assign store     = i_cmd.commit && keep && room;
    assign clr_write = i_cmd.clr_step && o_sts.clr_busy;
    assign clear_n   = (32'(r_atom_count) < 32'(nlpf_pkg::MAX_ATOMS))
                       ? nlpf_pkg::CLR_W'(r_atom_count)
                       : nlpf_pkg::CLR_W'(nlpf_pkg::MAX_ATOMS);

    assign o_sts.clr_busy = (r_clr_idx < r_clr_lim);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // single write port of the count memory: sweep or append
    always_comb begin
        len_we    = clr_write || store;
        len_waddr = clr_write ? r_clr_idx[nlpf_pkg::ATOM_AW-1:0] : home_addr;
        len_wdata = clr_write ? '0 : r_len_rd + nlpf_pkg::LEN_W'(1);
    end

    assign entry_ok = (r_op == nlpf_pkg::OP_READ) && home_ok &&
                      (32'(r_slot) < 32'(r_len_rd)) &&
                      (32'(r_slot) < 32'(nlpf_pkg::MAX_NEIGHBORS));
    assign d2_sat   = (nlpf_pkg::CMP_W'(r_acc) > nlpf_pkg::CMP_W'(nlpf_pkg::D2_MAX))
                      ? nlpf_pkg::D2_MAX : nlpf_pkg::D2_W'(r_acc);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x      <= nlpf_pkg::BOX_RESET;
            r_box_y      <= nlpf_pkg::BOX_RESET;
            r_box_z      <= nlpf_pkg::BOX_RESET;
            r_shell      <= nlpf_pkg::SHELL_RESET;
            r_atom_count <= nlpf_pkg::ACNT_RESET;
            r_clr_idx    <= '0;
            r_clr_lim    <= nlpf_pkg::CLR_W'(nlpf_pkg::MAX_ATOMS);
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nlpf_pkg::REG_BOX_X: r_box_x <= i_cfg_data[nlpf_pkg::BOX_W-1:0];
                    nlpf_pkg::REG_BOX_Y: r_box_y <= i_cfg_data[nlpf_pkg::BOX_W-1:0];
                    nlpf_pkg::REG_BOX_Z: r_box_z <= i_cfg_data[nlpf_pkg::BOX_W-1:0];
                    nlpf_pkg::REG_SHELL: r_shell <= i_cfg_data[nlpf_pkg::D2_W-1:0];
                    nlpf_pkg::REG_ATOM_COUNT: begin
                        r_atom_count <= i_cfg_data[nlpf_pkg::ACNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_start) begin
                r_clr_idx <= '0;
                r_clr_lim <= clear_n;
            end else if (clr_write) begin
                r_clr_idx <= r_clr_idx + nlpf_pkg::CLR_W'(1);
            end
            if (i_cmd.clr_start) begin
                r_total <= '0;
            end else if (store) begin
                r_total <= r_total + nlpf_pkg::TOT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_operation;
            r_home  <= i_home_atom;
            r_other <= i_other_atom;
            r_hx    <= i_home_x;
            r_hy    <= i_home_y;
            r_hz    <= i_home_z;
            r_ox    <= i_other_x;
            r_oy    <= i_other_y;
            r_oz    <= i_other_z;
            r_slot  <= i_slot;
            r_acc   <= '0;
            r_added <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.acc) r_acc <= r_acc + nlpf_pkg::SUM_W'(r_sq);
            if (i_cmd.commit && keep) begin
                r_added <= room;
                r_ovf   <= !room;
            end
        end
        if (i_cmd.diff) r_diff <= diff_val;
        if (i_cmd.wrap) r_mag  <= mag_w[nlpf_pkg::COORD_BITS-1:0];
        if (i_cmd.mult) r_sq   <= r_mag * r_mag;
        if (i_cmd.load_out) begin
            r_o_added <= r_added;
            r_o_ovf   <= r_ovf;
            r_o_cnt   <= home_ok
                         ? nlpf_pkg::CNT_W'(r_len_rd + nlpf_pkg::LEN_W'(r_added)) : '0;
            r_o_ent   <= entry_ok ? r_ent_rd : '0;
            r_o_d2    <= (r_op == nlpf_pkg::OP_PAIR) ? d2_sat : '0;
            r_o_tot   <= r_total;
        end
    end

    // list count memory
    always_ff @(posedge i_clk) begin
        if (len_we) len_mem[len_waddr] <= len_wdata;
        if (i_cmd.len_rd) r_len_rd <= len_mem[home_addr];
    end

    // list entry memory
    always_ff @(posedge i_clk) begin
        if (store) begin
            ent_mem[{home_addr, nlpf_pkg::SLOT_AW'(r_len_rd)}] <= r_other;
        end
        if (i_cmd.ent_rd) begin
            r_ent_rd <= ent_mem[{home_addr, nlpf_pkg::SLOT_AW'(r_slot)}];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_added            = r_o_added;
    assign o_overflow         = r_o_ovf;
    assign o_neighbor_count   = r_o_cnt;
    assign o_entry_value      = r_o_ent;
    assign o_distance_squared = r_o_d2;
    assign o_total_neighbors  = r_o_tot;

endmodule

FILE: hw/rtl/neighbor_list_pair_filter.sv
// ----------------------------------------------------------------------------
// neighbor_list_pair_filter
// verlet neighbor list builder with minimum-image pair test
// ----------------------------------------------------------------------------
// one request at a time: a pair test walks a diff, wrap, square and
// accumulate step per axis, the three wrapped axis differences squared in
// turn by the single shared 24x24 multiplier, then reads the home list
// count and appends; a list read reads the count and the entry, a no-op
// the count only; a clear sweeps min(atom_count, 4096) list counts
// through the one write port of the count memory, one list count per
// cycle; after reset the same sweep runs over all 4096 list counts while
// the input is not ready (register writes are taken throughout); a
// finished result sits in an output register, so a new request is taken
// while the previous result waits
// ----------------------------------------------------------------------------
module neighbor_list_pair_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register write port
    input  logic                              i_cfg_we,
    input  logic [nlpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nlpf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [nlpf_pkg::OP_W-1:0]         i_operation,
    input  logic [nlpf_pkg::ATOM_W-1:0]       i_home_atom,
    input  logic [nlpf_pkg::ATOM_W-1:0]       i_other_atom,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_x,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_y,
    input  logic [nlpf_pkg::POS_W-1:0]        i_home_z,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_x,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_y,
    input  logic [nlpf_pkg::POS_W-1:0]        i_other_z,
    input  logic [nlpf_pkg::SLOT_W-1:0]       i_slot,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_added,
    output logic                              o_overflow,
    output logic [nlpf_pkg::CNT_W-1:0]        o_neighbor_count,
    output logic [nlpf_pkg::ATOM_W-1:0]       o_entry_value,
    output logic [nlpf_pkg::D2_W-1:0]         o_distance_squared,
    output logic [nlpf_pkg::TOT_W-1:0]        o_total_neighbors
);

    // step commands down, sweep and result-slot status up
    nlpf_pkg::t_cmd w_cmd;
    nlpf_pkg::t_sts w_sts;

    // sequencer: decodes the request operation, walks the per-axis steps
    // and waits for the result register before retiring a request
    nlpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: config registers, minimum-image wrap, square/accumulate,
    // list count and entry memories, running total and result register
    nlpf_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_home_atom        (i_home_atom),
        .i_other_atom       (i_other_atom),
        .i_home_x           (i_home_x),
        .i_home_y           (i_home_y),
        .i_home_z           (i_home_z),
        .i_other_x          (i_other_x),
        .i_other_y          (i_other_y),
        .i_other_z          (i_other_z),
        .i_slot             (i_slot),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_added            (o_added),
        .o_overflow         (o_overflow),
        .o_neighbor_count   (o_neighbor_count),
        .o_entry_value      (o_entry_value),
        .o_distance_squared (o_distance_squared),
        .o_total_neighbors  (o_total_neighbors)
    );

endmodule

FILE: hw/rtl/nlpf_checker.sv
// ----------------------------------------------------------------------------
// nlpf_checker
// port-level checks on the pair filter result channel
// ----------------------------------------------------------------------------
`include "neighbor_list_pair_filter_defines.svh"

module nlpf_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_added,
    input  logic                        o_overflow,
    input  logic [nlpf_pkg::CNT_W-1:0]  o_neighbor_count,
    input  logic [nlpf_pkg::ATOM_W-1:0] o_entry_value,
    input  logic [nlpf_pkg::D2_W-1:0]   o_distance_squared,
    input  logic [nlpf_pkg::TOT_W-1:0]  o_total_neighbors
);

    // stalled result stays offered
    `NLPF_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // stalled result count, total, distance and entry do not move
    `NLPF_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_neighbor_count) && $stable(o_total_neighbors) && $stable(o_distance_squared) && $stable(o_entry_value), "result payload changed while stalled")

    // an append leaves a non-empty list and is never also an overflow
    `NLPF_ASSERT_NOW(a_added_count, o_out_valid && o_added, !o_overflow && (o_neighbor_count != '0) && (o_total_neighbors != '0), "append with empty list or overflow")

    // overflow only on a full list
    `NLPF_ASSERT_NOW(a_ovf_full, o_out_valid && o_overflow, o_neighbor_count == nlpf_pkg::CNT_W'(nlpf_pkg::MAX_NEIGHBORS), "overflow on a list that is not full")

    // a non-zero entry comes only from a read of a non-empty list
    `NLPF_ASSERT_NOW(a_entry_read, o_out_valid && (o_entry_value != '0), !o_added && !o_overflow && (o_distance_squared == '0) && (o_neighbor_count != '0), "entry value outside a list read")

endmodule

bind neighbor_list_pair_filter nlpf_checker u_nlpf_checker (.*);
